@@ rtl/core/sft_pkg.sv @@
// ----------------------------------------------------------------------------
// sft_pkg: shared types and constants for the friction torque core
// Field widths, configuration register indexes and the exp(-x) table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sft_pkg;

    // Field widths
    localparam int VEL_W     = 18;   // signed Q5.12 joint velocity
    localparam int TRQ_W     = 32;   // signed Q19.12 friction torque
    localparam int COEF_W    = 16;   // unsigned Q8.8 coefficients and rates
    localparam int CFG_IDX_W = 3;
    localparam int EXP_W     = 17;   // Q1.16 exp value, 1.0 = 65536
    localparam int FRAC_W    = 20;   // interpolation fraction

    // exp(-x) table depth: default and largest supported
    localparam int EXP_TABLE_DEPTH_DEF = 256;
    localparam int EXP_DEPTH_MAX       = 4096;

    // Register stages from input to output
    localparam int SFT_STAGES = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS_COEFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIBECK_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COULOMB_COEFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COULOMB_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIBECK_RATE  = 3'd4;

    typedef logic signed [VEL_W-1:0] t_vel;
    typedef logic signed [TRQ_W-1:0] t_trq;
    typedef logic [EXP_W-1:0]        t_exp_rom [0:EXP_DEPTH_MAX];

    // Table of exp(-k*h): repeated Q0.31 multiply by q = exp(-h), rounded to Q1.16.
    // Entries past depth are unused and held at zero.
    function automatic t_exp_rom sft_build_rom(input longint unsigned q,
                                               input int unsigned depth);
        t_exp_rom rom;
        longint unsigned e;
        e = 64'h8000_0000;
        for (int unsigned k = 0; k <= EXP_DEPTH_MAX; k++) begin
            if (k <= depth) begin
                rom[k] = EXP_W'((e + 64'h4000) >> 15);
                e = (e * q + 64'h4000_0000) >> 31;
            end else begin
                rom[k] = '0;
            end
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sft_vel_if.sv @@
// ----------------------------------------------------------------------------
// sft_vel_if: joint velocity request channel
// valid/ready handshake carrying one signed Q5.12 velocity sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface sft_vel_if;
    import sft_pkg::*;

    logic valid;
    logic ready;
    t_vel joint_velocity;

    modport source (output valid, output joint_velocity, input ready);
    modport sink   (input valid, input joint_velocity, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sft_trq_if.sv @@
// ----------------------------------------------------------------------------
// sft_trq_if: friction torque result channel
// valid/ready handshake carrying one signed Q19.12 torque value.
// ----------------------------------------------------------------------------
`default_nettype none

interface sft_trq_if;
    import sft_pkg::*;

    logic valid;
    logic ready;
    t_trq torque;

    modport source (output valid, output torque, input ready);
    modport sink   (input valid, input torque, output ready);
endinterface

`default_nettype wire

@@ rtl/core/stribeck_friction_torque_core.sv @@
// ----------------------------------------------------------------------------
// stribeck_friction_torque_core: viscous + Stribeck + Coulomb friction torque
// tau = fv*v + fs*sgn(v)*exp(-f2|v|) + fc*sgn(v)*(1-exp(-f1|v|)), fixed point,
// with exp(-x) from a constant table and linear interpolation.
// ----------------------------------------------------------------------------
//  channel   dir  payload                       width
//  i_vel     in   joint_velocity  (Q5.12)       18 signed
//  o_trq     out  torque          (Q19.12)      32 signed
//  i_cfg_*   in   5 x 16-bit coefficient regs   idx 3, data 16
//
//  One request per cycle, unless a stalled output has filled the 8-stage pipeline.
//  Each stage holds its data while the stage after it is full and stalled;
//  a bubble anywhere lets the stages before it keep moving.
//  Synchronous active-low reset clears the valid bits and the configuration registers;
//  the exp table is constant logic and needs no fill after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stribeck_friction_torque_core #(
    parameter int EXP_TABLE_DEPTH = sft_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    sft_vel_if.sink                            i_vel,
    sft_trq_if.source                          o_trq,
    input  wire                                i_cfg_we,
    input  wire  [sft_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [sft_pkg::COEF_W-1:0]         i_cfg_data
);
    import sft_pkg::*;

    localparam int NS  = SFT_STAGES;
    localparam int XW  = COEF_W + VEL_W;           // rate * |v|, Q.20
    localparam int DW  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int RW  = $clog2(EXP_DEPTH_MAX + 1); // table address
    localparam int PW  = XW + DW;                  // x * depth
    localparam int KW  = PW - 24;                  // integer part of table position
    localparam int PRW = COEF_W + EXP_W;           // coefficient * exp
    localparam int SW  = XW + 6;                   // Q.24 sum with headroom
    localparam int TW  = SW - 12;                  // rounded Q.12 magnitude

    // Table step and exp(-h) from a Taylor sum through the h^24 term, all in Q0.31
    localparam longint unsigned EXP_ONE = 64'h8000_0000;
    localparam longint unsigned EXP_H   = (64'd16 << 31) / EXP_TABLE_DEPTH;
    localparam longint unsigned EXP_T01 = ((EXP_ONE * EXP_H) >> 31) / 1;
    localparam longint unsigned EXP_T02 = ((EXP_T01 * EXP_H) >> 31) / 2;
    localparam longint unsigned EXP_T03 = ((EXP_T02 * EXP_H) >> 31) / 3;
    localparam longint unsigned EXP_T04 = ((EXP_T03 * EXP_H) >> 31) / 4;
    localparam longint unsigned EXP_T05 = ((EXP_T04 * EXP_H) >> 31) / 5;
    localparam longint unsigned EXP_T06 = ((EXP_T05 * EXP_H) >> 31) / 6;
    localparam longint unsigned EXP_T07 = ((EXP_T06 * EXP_H) >> 31) / 7;
    localparam longint unsigned EXP_T08 = ((EXP_T07 * EXP_H) >> 31) / 8;
    localparam longint unsigned EXP_T09 = ((EXP_T08 * EXP_H) >> 31) / 9;
    localparam longint unsigned EXP_T10 = ((EXP_T09 * EXP_H) >> 31) / 10;
    localparam longint unsigned EXP_T11 = ((EXP_T10 * EXP_H) >> 31) / 11;
    localparam longint unsigned EXP_T12 = ((EXP_T11 * EXP_H) >> 31) / 12;
    localparam longint unsigned EXP_T13 = ((EXP_T12 * EXP_H) >> 31) / 13;
    localparam longint unsigned EXP_T14 = ((EXP_T13 * EXP_H) >> 31) / 14;
    localparam longint unsigned EXP_T15 = ((EXP_T14 * EXP_H) >> 31) / 15;
    localparam longint unsigned EXP_T16 = ((EXP_T15 * EXP_H) >> 31) / 16;
    localparam longint unsigned EXP_T17 = ((EXP_T16 * EXP_H) >> 31) / 17;
    localparam longint unsigned EXP_T18 = ((EXP_T17 * EXP_H) >> 31) / 18;
    localparam longint unsigned EXP_T19 = ((EXP_T18 * EXP_H) >> 31) / 19;
    localparam longint unsigned EXP_T20 = ((EXP_T19 * EXP_H) >> 31) / 20;
    localparam longint unsigned EXP_T21 = ((EXP_T20 * EXP_H) >> 31) / 21;
    localparam longint unsigned EXP_T22 = ((EXP_T21 * EXP_H) >> 31) / 22;
    localparam longint unsigned EXP_T23 = ((EXP_T22 * EXP_H) >> 31) / 23;
    localparam longint unsigned EXP_T24 = ((EXP_T23 * EXP_H) >> 31) / 24;
    localparam longint unsigned EXP_POS = EXP_ONE + EXP_T02 + EXP_T04 + EXP_T06
        + EXP_T08 + EXP_T10 + EXP_T12 + EXP_T14 + EXP_T16 + EXP_T18 + EXP_T20
        + EXP_T22 + EXP_T24;
    localparam longint unsigned EXP_NEG = EXP_T01 + EXP_T03 + EXP_T05 + EXP_T07
        + EXP_T09 + EXP_T11 + EXP_T13 + EXP_T15 + EXP_T17 + EXP_T19 + EXP_T21
        + EXP_T23;
    localparam longint unsigned EXP_Q = (EXP_POS > EXP_NEG) ? (EXP_POS - EXP_NEG) : 64'd0;

    localparam t_exp_rom EXP_ROM = sft_build_rom(EXP_Q, EXP_TABLE_DEPTH);

    // Configuration registers
    logic [COEF_W-1:0] r_visc_coef;
    logic [COEF_W-1:0] r_str_coef;
    logic [COEF_W-1:0] r_cou_coef;
    logic [COEF_W-1:0] r_cou_rate;
    logic [COEF_W-1:0] r_str_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visc_coef <= '0;
            r_str_coef  <= '0;
            r_cou_coef  <= '0;
            r_cou_rate  <= '0;
            r_str_rate  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VISCOUS_COEFF:  r_visc_coef <= i_cfg_data;
                CFG_STRIBECK_COEFF: r_str_coef  <= i_cfg_data;
                CFG_COULOMB_COEFF:  r_cou_coef  <= i_cfg_data;
                CFG_COULOMB_RATE:   r_cou_rate  <= i_cfg_data;
                CFG_STRIBECK_RATE:  r_str_rate  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage loads when it is empty or its successor loads
    logic [NS:1] r_vld;
    logic [NS:1] go;

    always_comb begin
        go[NS] = !r_vld[NS] || o_trq.ready;
        for (int s = NS - 1; s >= 1; s--) begin
            go[s] = !r_vld[s] || go[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (go[1]) begin
                r_vld[1] <= i_vel.valid;
            end
            for (int s = 2; s <= NS; s++) begin
                if (go[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign i_vel.ready = go[1];

    // Unit 0 is the Stribeck exponential, unit 1 the Coulomb one.

    // Stage 1: sign and magnitude of the velocity
    logic [VEL_W-1:0] n_s1_raw;
    logic [VEL_W-1:0] r_s1_mag;
    logic             r_s1_neg;
    logic             r_s1_zero;

    assign n_s1_raw = i_vel.joint_velocity;

    always_ff @(posedge i_clk) begin
        if (go[1]) begin
            r_s1_neg  <= n_s1_raw[VEL_W-1];
            r_s1_zero <= (n_s1_raw == '0);
            r_s1_mag  <= n_s1_raw[VEL_W-1] ? (VEL_W'(0) - n_s1_raw) : n_s1_raw;
        end
    end

    // Stage 2: exponents rate*|v| and the viscous product
    logic [XW-1:0] r_s2_x [2];
    logic [XW-1:0] r_s2_visc;
    logic          r_s2_neg;
    logic          r_s2_zero;

    always_ff @(posedge i_clk) begin
        if (go[2]) begin
            r_s2_x[0]  <= XW'(r_str_rate) * XW'(r_s1_mag);
            r_s2_x[1]  <= XW'(r_cou_rate) * XW'(r_s1_mag);
            r_s2_visc  <= XW'(r_visc_coef) * XW'(r_s1_mag);
            r_s2_neg   <= r_s1_neg;
            r_s2_zero  <= r_s1_zero;
        end
    end

    // Stage 3: table position x*depth/16, split into index and fraction
    logic [PW-1:0]     n_s3_p   [2];
    logic [KW-1:0]     n_s3_kf  [2];
    logic              n_s3_ov  [2];
    logic [DW-1:0]     r_s3_k   [2];
    logic [FRAC_W-1:0] r_s3_fr  [2];
    logic              r_s3_ov  [2];
    logic [XW-1:0]     r_s3_visc;
    logic              r_s3_neg;
    logic              r_s3_zero;

    always_comb begin
        for (int u = 0; u < 2; u++) begin
            n_s3_p[u]  = PW'(r_s2_x[u]) * PW'(EXP_TABLE_DEPTH);
            n_s3_kf[u] = n_s3_p[u][PW-1:24];
            n_s3_ov[u] = (n_s3_kf[u] >= KW'(EXP_TABLE_DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[3]) begin
            for (int u = 0; u < 2; u++) begin
                r_s3_k[u]  <= n_s3_ov[u] ? '0 : n_s3_kf[u][DW-1:0];
                r_s3_fr[u] <= n_s3_p[u][23:4];
                r_s3_ov[u] <= n_s3_ov[u];
            end
            r_s3_visc <= r_s2_visc;
            r_s3_neg  <= r_s2_neg;
            r_s3_zero <= r_s2_zero;
        end
    end

    // Stage 4: table lookup of both neighbors; past the end exp is zero
    logic [EXP_W-1:0]  r_s4_a  [2];
    logic [EXP_W-1:0]  r_s4_b  [2];
    logic [FRAC_W-1:0] r_s4_fr [2];
    logic [XW-1:0]     r_s4_visc;
    logic              r_s4_neg;
    logic              r_s4_zero;

    always_ff @(posedge i_clk) begin
        if (go[4]) begin
            for (int u = 0; u < 2; u++) begin
                r_s4_a[u]  <= r_s3_ov[u] ? '0 : EXP_ROM[RW'(r_s3_k[u])];
                r_s4_b[u]  <= r_s3_ov[u] ? '0 : EXP_ROM[RW'(r_s3_k[u]) + RW'(1)];
                r_s4_fr[u] <= r_s3_fr[u];
            end
            r_s4_visc <= r_s3_visc;
            r_s4_neg  <= r_s3_neg;
            r_s4_zero <= r_s3_zero;
        end
    end

    // Stage 5: interpolation step, (a-b)*fr rounded to Q1.16
    logic [EXP_W-1:0]          n_s5_diff [2];
    logic [EXP_W+FRAC_W-1:0]   n_s5_prod [2];
    logic [EXP_W-1:0]          r_s5_a    [2];
    logic [EXP_W-1:0]          r_s5_d    [2];
    logic [XW-1:0]             r_s5_visc;
    logic                      r_s5_neg;
    logic                      r_s5_zero;

    always_comb begin
        for (int u = 0; u < 2; u++) begin
            n_s5_diff[u] = (r_s4_a[u] >= r_s4_b[u]) ? (r_s4_a[u] - r_s4_b[u]) : '0;
            n_s5_prod[u] = (EXP_W+FRAC_W)'(n_s5_diff[u]) * (EXP_W+FRAC_W)'(r_s4_fr[u])
                         + (EXP_W+FRAC_W)'(1 << (FRAC_W - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[5]) begin
            for (int u = 0; u < 2; u++) begin
                r_s5_a[u] <= r_s4_a[u];
                r_s5_d[u] <= n_s5_prod[u][EXP_W+FRAC_W-1:FRAC_W];
            end
            r_s5_visc <= r_s4_visc;
            r_s5_neg  <= r_s4_neg;
            r_s5_zero <= r_s4_zero;
        end
    end

    // Stage 6: finish exp, scale by the amplitudes
    logic [EXP_W-1:0] n_s6_e [2];
    logic [PRW-1:0]   r_s6_ps;
    logic [PRW-1:0]   r_s6_pc;
    logic [XW-1:0]    r_s6_visc;
    logic             r_s6_neg;
    logic             r_s6_zero;

    always_comb begin
        for (int u = 0; u < 2; u++) begin
            n_s6_e[u] = (r_s5_a[u] >= r_s5_d[u]) ? (r_s5_a[u] - r_s5_d[u]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[6]) begin
            r_s6_ps   <= PRW'(r_str_coef) * PRW'(n_s6_e[0]);
            r_s6_pc   <= PRW'(r_cou_coef) * PRW'(EXP_W'(1 << 16) - n_s6_e[1]);
            r_s6_visc <= r_s5_visc;
            r_s6_neg  <= r_s5_neg;
            r_s6_zero <= r_s5_zero;
        end
    end

    // Stage 7: Q.24 sum, round half away from zero (on the magnitude) to Q.12
    logic [SW-1:0] n_s7_sum;
    logic [TW-1:0] r_s7_t;
    logic          r_s7_neg;
    logic          r_s7_zero;

    assign n_s7_sum = SW'({r_s6_visc, 4'b0000}) + SW'(r_s6_ps) + SW'(r_s6_pc)
                    + SW'(1 << 11);

    always_ff @(posedge i_clk) begin
        if (go[7]) begin
            r_s7_t    <= n_s7_sum[SW-1:12];
            r_s7_neg  <= r_s6_neg;
            r_s7_zero <= r_s6_zero;
        end
    end

    // Stage 8: apply sign; magnitude stays below 2^28, inside the output range
    logic [TRQ_W-1:0] n_s8_mag;
    t_trq             r_s8_trq;

    assign n_s8_mag = TRQ_W'(r_s7_t);

    always_ff @(posedge i_clk) begin
        if (go[8]) begin
            if (r_s7_zero) begin
                r_s8_trq <= '0;
            end else if (r_s7_neg) begin
                r_s8_trq <= TRQ_W'(0) - n_s8_mag;
            end else begin
                r_s8_trq <= n_s8_mag;
            end
        end
    end

    assign o_trq.valid  = r_vld[NS];
    assign o_trq.torque = r_s8_trq;

endmodule

`default_nettype wire

@@ rtl/core/sft_chk.sv @@
// ----------------------------------------------------------------------------
// sft_chk: port-level checks for the friction torque core
// Tracks requests in flight and checks output hold and backpressure behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module sft_chk (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       i_in_ready,
    input wire                       i_out_valid,
    input wire                       i_out_ready,
    input wire [sft_pkg::TRQ_W-1:0]  i_out_torque
);
    import sft_pkg::*;

    localparam int CW = $clog2(SFT_STAGES + 1) + 1;

    logic          in_acc;
    logic          out_acc;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // requests in flight
    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!in_acc && out_acc) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_torque))
        else $error("result dropped or changed while stalled");

    // input backpressure only when every stage is full behind a stalled output
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a stalled output");

    // never more requests in flight than pipeline stages
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SFT_STAGES))
        else $error("more requests in flight than stages");

    // no result without an outstanding request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result without a request");

endmodule

bind stribeck_friction_torque_core sft_chk u_sft_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_vel.valid),
    .i_in_ready   (i_vel.ready),
    .i_out_valid  (o_trq.valid),
    .i_out_ready  (o_trq.ready),
    .i_out_torque (o_trq.torque)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stribeck_friction_torque_core
// Drives joint velocity requests and coefficient settings, predicts each
// friction torque with a bit-accurate fixed-point model held in the bench and
// compares every torque result in order. Sender gaps, receiver stalls, a long
// output hold-off and drain pauses exercise the pipeline handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sft_pkg::*;

    localparam int EXP_DEPTH   = EXP_TABLE_DEPTH_DEF;
    localparam int VEL_MAX     = 2**(VEL_W-1) - 1;
    localparam int VEL_MIN     = -(2**(VEL_W-1));
    localparam int GAP_MAX     = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 20_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    sft_vel_if vel_if ();
    sft_trq_if trq_if ();

    stribeck_friction_torque_core #(
        .EXP_TABLE_DEPTH (EXP_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vel      (vel_if),
        .o_trq      (trq_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Bench copy of the coefficient registers and the exp(-x) table
    logic [COEF_W-1:0] coef_viscous;
    logic [COEF_W-1:0] coef_stribeck;
    logic [COEF_W-1:0] coef_coulomb;
    logic [COEF_W-1:0] rate_coulomb;
    logic [COEF_W-1:0] rate_stribeck;
    longint unsigned   exp_table [0:EXP_DEPTH];

    t_trq torque_expected [$];
    t_trq torque_want;

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_left;
    int fail_count;
    int requests_sent;
    int results_checked;
    int settings_loaded;
    int input_stall_cycles;
    int cycle_count;

    // exp(-k*h) samples, h = 16/depth: Taylor series for exp(-h) in Q0.31,
    // then repeated rounded multiply, each sample rounded to Q1.16
    function automatic void build_exp_table();
        longint unsigned step;
        longint unsigned term;
        longint unsigned pos_sum;
        longint unsigned neg_sum;
        longint unsigned ratio;
        longint unsigned e;
        step    = (64'd16 << 31) / EXP_DEPTH;
        term    = 64'd1 << 31;
        pos_sum = term;
        neg_sum = 0;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * step) >> 31) / n;
            if (n % 2) neg_sum += term;
            else       pos_sum += term;
        end
        ratio = (pos_sum > neg_sum) ? pos_sum - neg_sum : 0;
        e = 64'd1 << 31;
        for (int k = 0; k <= EXP_DEPTH; k++) begin
            exp_table[k] = (e + (64'd1 << 14)) >> 15;
            e = (e * ratio + (64'd1 << 30)) >> 31;
        end
    endfunction

    // exp(-x), x in Q.20, result Q1.16; zero once the index runs off the table
    function automatic longint unsigned exp_decay_q16(input longint unsigned x);
        longint unsigned pos;
        longint unsigned k;
        longint unsigned fr;
        longint unsigned a;
        longint unsigned b;
        longint unsigned d;
        pos = (x * EXP_DEPTH) >> 4;
        k   = pos >> FRAC_W;
        fr  = pos & ((64'd1 << FRAC_W) - 1);
        if (k >= EXP_DEPTH) return 0;
        a = exp_table[k];
        b = exp_table[k + 1];
        d = (a >= b) ? a - b : 0;
        d = (d * fr + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        return (a >= d) ? a - d : 0;
    endfunction

    // Torque in Q19.12: magnitude summed in Q.24, rounded half away from zero,
    // clamped, then the velocity sign applied
    function automatic t_trq torque_of(input t_vel v);
        logic [VEL_W-1:0] raw;
        bit               is_neg;
        longint unsigned  mag;
        longint unsigned  acc;
        longint unsigned  t;
        raw    = v;
        is_neg = raw[VEL_W-1];
        mag    = is_neg ? (64'd1 << VEL_W) - raw : raw;
        if (mag == 0) return '0;
        acc = (coef_viscous * mag) << 4;
        acc += coef_stribeck * exp_decay_q16(rate_stribeck * mag);
        acc += coef_coulomb * (64'd65536 - exp_decay_q16(rate_coulomb * mag));
        t = (acc + (64'd1 << 11)) >> 12;
        if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
        return is_neg ? t_trq'(-t) : t_trq'(t);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [COEF_W-1:0] val);
        case (idx)
            CFG_VISCOUS_COEFF:  coef_viscous  = val;
            CFG_STRIBECK_COEFF: coef_stribeck = val;
            CFG_COULOMB_COEFF:  coef_coulomb  = val;
            CFG_COULOMB_RATE:   rate_coulomb  = val;
            CFG_STRIBECK_RATE:  rate_stribeck = val;
            default: ;  // unused index: write is dropped
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coeff();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return COEF_W'($urandom_range(255));
            3:       return COEF_W'($urandom_range(4095));
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Mostly full-range samples, some small ones, a few range corners
    function automatic t_vel pick_velocity();
        int sel;
        int corner;
        int mag;
        sel = $urandom_range(9);
        if (sel == 0) begin
            corner = $urandom_range(3);
            return (corner == 0) ? t_vel'(VEL_MAX) :
                   (corner == 1) ? t_vel'(VEL_MIN) :
                   (corner == 2) ? t_vel'(1) : t_vel'(-1);
        end
        if (sel <= 3) begin
            mag = $urandom_range(1023);
            return $urandom_range(1) ? t_vel'(-mag) : t_vel'(mag);
        end
        return t_vel'($urandom);
    endfunction

    // One velocity request; the expected torque is queued when it is accepted
    task automatic send_velocity(input t_vel v);
        int gap;
        gap = 0;
        vel_if.valid          <= 1'b1;
        vel_if.joint_velocity <= v;
        do @(posedge i_clk); while (!vel_if.ready);
        torque_expected.push_back(torque_of(v));
        requests_sent++;
        while (gap < GAP_MAX && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            vel_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        vel_if.valid <= 1'b0;
        while (torque_expected.size() != 0) @(posedge i_clk);
    endtask

    // Drained and the pipeline flushed: safe to touch the registers
    task automatic wait_idle();
        wait_drained();
        repeat (SFT_STAGES + 2) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    // Writes all five registers plus one write to an unused index
    task automatic load_coeffs(input logic [COEF_W-1:0] fv, input logic [COEF_W-1:0] fs,
                               input logic [COEF_W-1:0] fc, input logic [COEF_W-1:0] f1,
                               input logic [COEF_W-1:0] f2);
        int bad_idx;
        bad_idx = $urandom_range(2**CFG_IDX_W - 1, CFG_STRIBECK_RATE + 1);
        wait_idle();
        put_reg(CFG_VISCOUS_COEFF, fv);
        put_reg(CFG_STRIBECK_COEFF, fs);
        put_reg(CFG_COULOMB_COEFF, fc);
        put_reg(CFG_COULOMB_RATE, f1);
        put_reg(CFG_STRIBECK_RATE, f2);
        put_reg(CFG_IDX_W'(bad_idx), COEF_W'($urandom));
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic load_random_coeffs();
        load_coeffs(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // Zero velocity, range corners, table end crossing, sign symmetry
    task automatic test_directed();
        int corners [9] = '{0, 1, -1, VEL_MAX, VEL_MIN, 4096, -4096, 256, -257};
        int halves  [6] = '{1, -1, 2048, -2048, 4096, -4096};
        set_idling(0, 0);
        // registers still at reset values
        send_velocity(t_vel'(0));
        send_velocity(t_vel'(1));
        send_velocity(t_vel'(VEL_MIN));
        // all coefficients and rates at full scale; |v| = 257 runs off the table
        load_coeffs('1, '1, '1, '1, '1);
        foreach (corners[i]) send_velocity(t_vel'(corners[i]));
        // flat Stribeck term (zero rate) with a slow Coulomb ramp
        load_coeffs('0, 16'h0100, 16'h0200, 16'h0080, '0);
        foreach (halves[i]) send_velocity(t_vel'(halves[i]));
    endtask

    // Random traffic under each sender / receiver idling mix
    task automatic test_idling_phases();
        int tx_mix [4] = '{0, 77, 0, 35};
        int rx_mix [4] = '{0, 0, 77, 35};
        for (int m = 0; m < 4; m++) begin
            set_idling(tx_mix[m], rx_mix[m]);
            repeat (3) begin
                load_random_coeffs();
                repeat (130) send_velocity(pick_velocity());
            end
        end
    endtask

    // Output held off while requests keep coming: pipeline fills, input stalls
    task automatic test_backpressure();
        set_idling(0, 0);
        load_random_coeffs();
        rx_hold_left <= HOLD_CYCLES;
        repeat (40) send_velocity(pick_velocity());
        wait_drained();
    endtask

    // Short bursts, each followed by a full drain
    task automatic test_drain_pauses();
        set_idling(35, 35);
        load_random_coeffs();
        repeat (8) begin
            repeat (8) send_velocity(pick_velocity());
            wait_drained();
        end
    endtask

    // Receiver ready: long hold-off when requested, else random stalls
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            trq_if.ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            trq_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result check against the oldest expected torque
    always @(posedge i_clk) begin
        if (i_rst_n && trq_if.valid && trq_if.ready) begin
            if (torque_expected.size() == 0) begin
                $error("torque: no result expected, actual %0d",
                       trq_if.torque);
                fail_count++;
            end else begin
                torque_want = torque_expected.pop_front();
                if (trq_if.torque !== torque_want) begin
                    $error("torque: expected %0d, actual %0d",
                           torque_want, trq_if.torque);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vel_if.valid && !vel_if.ready) input_stall_cycles++;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int drain_wait;
        vel_if.valid          = 1'b0;
        vel_if.joint_velocity = '0;
        trq_if.ready          = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        coef_viscous          = '0;
        coef_stribeck         = '0;
        coef_coulomb          = '0;
        rate_coulomb          = '0;
        rate_stribeck         = '0;
        tx_idle_pct           = 0;
        rx_stall_pct          = 0;
        rx_hold_left          = 0;
        fail_count            = 0;
        requests_sent         = 0;
        results_checked       = 0;
        settings_loaded       = 0;
        input_stall_cycles    = 0;
        cycle_count           = 0;
        drain_wait            = 0;
        build_exp_table();

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_idling_phases();
        test_backpressure();
        test_drain_pauses();

        // final drain, then a further wait to catch stray results
        vel_if.valid <= 1'b0;
        while (torque_expected.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SFT_STAGES * 4) @(posedge i_clk);
        if (torque_expected.size() != 0) begin
            $error("torque: %0d expected results never arrived",
                   torque_expected.size());
            fail_count++;
        end

        $display("Covered %0d velocity requests and %0d torque results",
                 requests_sent, results_checked);
        $display("over %0d register settings, with %0d cycles of input stall.",
                 settings_loaded, input_stall_cycles);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
